// ===== rtl/sha_pkg.sv =====
// ============================================================================
// sha_pkg
// Shared types and constants for the SHA-256 stream hasher: round constants,
// initial hash values, controller-to-datapath command and status structs.
// ============================================================================
package sha_pkg;

    localparam int unsigned BlockBits = 512;
    localparam int unsigned WordBits  = 32;
    localparam int unsigned NumWords  = 8;

    localparam logic [7:0] PadByte = 8'h80;

    localparam logic [WordBits-1:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [WordBits-1:0] IV_TABLE [NumWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [1:0] {
        SEL_DATA = 2'd0,
        SEL_PAD  = 2'd1,
        SEL_ZERO = 2'd2,
        SEL_LEN  = 2'd3
    } byte_sel_t;

    typedef struct packed {
        logic      shift_en;
        byte_sel_t byte_sel;
        logic      count_msg;
        logic      start_cmp;
        logic      round_en;
        logic      update_en;
        logic      emit_adv;
        logic      clear_msg;
    } sha_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic cnt_is_56;
        logic round_last;
        logic word_last;
    } sha_stat_t;

endpackage

// ===== rtl/sha_ctrl.sv =====
// ============================================================================
// sha_ctrl
// Controller FSM: accepts words, sequences padding, compression rounds,
// chaining update and digest emission.
// ============================================================================
module sha_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    output logic               out_valid,
    input  logic               out_stall,
    input  sha_pkg::sha_stat_t stat,
    output sha_pkg::sha_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PAD    = 5'b00010,
        ST_ROUND  = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   fin_reg, fin_next;
    logic   len_reg, len_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
            len_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            len_reg   <= len_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        len_next   = len_reg;
        cmd        = '0;
        cmd.byte_sel = sha_pkg::SEL_DATA;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.shift_en = 1'b1;
                    if (kind)
                    begin
                        cmd.byte_sel = sha_pkg::SEL_PAD;
                        fin_next     = 1'b1;
                        state_next   = ST_PAD;
                    end
                    else
                    begin
                        cmd.count_msg = 1'b1;
                    end
                    if (stat.cnt_last)
                    begin
                        cmd.start_cmp = 1'b1;
                        state_next    = ST_ROUND;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.shift_en = 1'b1;
                if (len_reg || stat.cnt_is_56)
                begin
                    cmd.byte_sel = sha_pkg::SEL_LEN;
                    len_next     = 1'b1;
                end
                else
                begin
                    cmd.byte_sel = sha_pkg::SEL_ZERO;
                end
                if (stat.cnt_last)
                begin
                    cmd.start_cmp = 1'b1;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (stat.round_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update_en = 1'b1;
                priority if (len_reg)
                    state_next = ST_EMIT;
                else if (fin_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    cmd.emit_adv = 1'b1;
                    if (stat.word_last)
                    begin
                        cmd.clear_msg = 1'b1;
                        fin_next      = 1'b0;
                        len_next      = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sha_dp.sv =====
// ============================================================================
// sha_dp
// Datapath: 512-bit block shift register doubling as the message schedule
// window, byte and bit counters, working variables, chaining state and
// the digest word select.
// ============================================================================
module sha_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         data_byte,
    input  sha_pkg::sha_cmd_t  cmd,
    output sha_pkg::sha_stat_t stat,
    output logic [31:0]        digest_word,
    output logic [2:0]         word_index,
    output logic               last_word
);

    logic [sha_pkg::BlockBits-1:0] blk_reg, blk_next;
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] h_reg [8];
    logic [31:0] h_next [8];
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;

    logic [7:0]  byte_in;
    logic [7:0]  len_byte;
    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] s0w, s1w, big_s0, big_s1, ch, maj, t1, t2;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    assign stat.cnt_last   = (cnt_reg == 6'd63);
    assign stat.cnt_is_56  = (cnt_reg == 6'd56);
    assign stat.round_last = (round_reg == 6'd63);
    assign stat.word_last  = (idx_reg == 3'd7);

    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

    // length bytes, most significant first, at block positions 56..63
    always_comb
    begin
        unique case (cnt_reg[2:0])
            3'd0: len_byte = bits_reg[63:56];
            3'd1: len_byte = bits_reg[55:48];
            3'd2: len_byte = bits_reg[47:40];
            3'd3: len_byte = bits_reg[39:32];
            3'd4: len_byte = bits_reg[31:24];
            3'd5: len_byte = bits_reg[23:16];
            3'd6: len_byte = bits_reg[15:8];
            3'd7: len_byte = bits_reg[7:0];
            default: len_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        unique case (cmd.byte_sel)
            sha_pkg::SEL_DATA: byte_in = data_byte;
            sha_pkg::SEL_PAD:  byte_in = sha_pkg::PadByte;
            sha_pkg::SEL_ZERO: byte_in = 8'h00;
            sha_pkg::SEL_LEN:  byte_in = len_byte;
            default:           byte_in = 8'h00;
        endcase
    end

    // schedule window: word t at the top of the block register
    assign w0  = blk_reg[511:480];
    assign w1  = blk_reg[479:448];
    assign w9  = blk_reg[223:192];
    assign w14 = blk_reg[63:32];
    assign s0w = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    assign s1w = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    assign w_new = s1w + w9 + s0w + w0;

    assign big_s1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
    assign ch     = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign big_s0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
    assign maj    = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1     = v_reg[7] + big_s1 + ch + sha_pkg::K_TABLE[round_reg] + w0;
    assign t2     = big_s0 + maj;

    always_comb
    begin
        blk_next   = blk_reg;
        cnt_next   = cnt_reg;
        bits_next  = bits_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        v_next     = v_reg;
        h_next     = h_reg;

        if (cmd.shift_en)
        begin
            blk_next = {blk_reg[503:0], byte_in};
            cnt_next = cnt_reg + 6'd1;
        end
        if (cmd.count_msg)
        begin
            bits_next = bits_reg + 64'd8;
        end
        if (cmd.start_cmp)
        begin
            v_next     = h_reg;
            round_next = 6'd0;
        end
        if (cmd.round_en)
        begin
            blk_next   = {blk_reg[479:0], w_new};
            round_next = round_reg + 6'd1;
            v_next[7]  = v_reg[6];
            v_next[6]  = v_reg[5];
            v_next[5]  = v_reg[4];
            v_next[4]  = v_reg[3] + t1;
            v_next[3]  = v_reg[2];
            v_next[2]  = v_reg[1];
            v_next[1]  = v_reg[0];
            v_next[0]  = t1 + t2;
        end
        if (cmd.update_en)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_next[i] = h_reg[i] + v_reg[i];
            end
        end
        if (cmd.emit_adv)
        begin
            idx_next = idx_reg + 3'd1;
        end
        if (cmd.clear_msg)
        begin
            h_next    = sha_pkg::IV_TABLE;
            bits_next = '0;
            cnt_next  = '0;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg     <= sha_pkg::IV_TABLE;
            cnt_reg   <= '0;
            bits_reg  <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            h_reg     <= h_next;
            cnt_reg   <= cnt_next;
            bits_reg  <= bits_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        v_reg   <= v_next;
    end

endmodule

// ===== rtl/sha256_stream_hasher_top.sv =====
// ============================================================================
// sha256_stream_hasher_top
// SHA-256 over a byte stream, one message byte or a finish marker per word.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): kind = 0 appends data_byte to the
// message; kind = 1 ends the message. in_stall is high whenever the block
// is busy; a word is taken only in the idle state.
// An append word shifts one byte into the block; the 64th byte of a block
// also starts compression: the rounds run on the single shared round unit,
// then the chaining update, and no new byte is taken until it is done.
// A finish word shifts padding in at one byte per cycle, pausing while
// each full block is compressed (up to 64 bytes, 72 when an extra block
// is needed), then presents eight digest words on the output channel.
// Output channel (out_valid / out_stall): digest_word, word_index 0..7,
// last_word on index 7. Each word is held until taken; a stall simply
// holds the current word. After the last word the block returns to the
// initial hash state and accepts the next message.
// Reset (rst_n low, asynchronous) loads the initial hash values and clears
// the byte and bit counters; no clearing pass is needed.
// ============================================================================
module sha256_stream_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha_pkg::sha_cmd_t  cmd;
    sha_pkg::sha_stat_t stat;

    sha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    sha_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .stat        (stat),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule
